// ===== src/gha_pkg.sv =====
// Shared types, constants and helpers for the generational handle allocator.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package gha_pkg;

   localparam int HANDLE_BITS     = 32;
   localparam int INDEX_BITS      = 24;
   localparam int GEN_BITS        = 8;
   localparam int SLOT_BITS       = 8;   // slots = 2**SLOT_BITS
   localparam int THRESHOLD_BITS  = 8;
   localparam int WAIT_BITS       = SLOT_BITS + 1;

   localparam logic [SLOT_BITS:0]      SLOT_TOTAL       = {1'b1, {SLOT_BITS{1'b0}}};
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 8'd32;

   // operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CHECK   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]             operation;
      logic [HANDLE_BITS-1:0] handle;
   } gha_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] new_handle;
      logic [WAIT_BITS-1:0]   free_waiting;
   } gha_rsp_type;

   // request after decode in the front end
   typedef struct packed {
      logic [1:0]           operation;
      logic [SLOT_BITS-1:0] index;
      logic [GEN_BITS-1:0]  gen;
      logic                 addr_ok;   // not all ones, upper index bits clear
   } gha_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOOKUP
   } gha_state_type;

   function automatic logic [HANDLE_BITS-1:0] make_handle(
      input logic [SLOT_BITS-1:0] index,
      input logic [GEN_BITS-1:0]  gen
   );
      logic [INDEX_BITS-1:0] full_index;
      full_index = INDEX_BITS'(index);
      return HANDLE_BITS'({gen, full_index});
   endfunction

endpackage

`default_nettype wire

// ===== src/generational_handle_allocator_top.sv =====
// Top level of the generational handle allocator: front end, back end and
// result queue. Depends on gha_pkg, gha_front, gha_back, gha_rsp_queue.
//
//   channel   ports                         transfer when
//   request   req_push/req_full/req_item    req_push && !req_full
//   result    rsp_empty/rsp_pop/rsp_item    rsp_pop && !rsp_empty
//   config    csr_we/csr_wdata              csr_we
//
// In the back end, release, check and new-slot allocate go idle (memory
// read) then execute (update); allocate that reuses a freed index adds a
// lookup state, as generation memory is reread at the dequeued index.
// Requests pass through a two-entry command queue; results wait in a
// two-entry queue, so the back end stalls only when that queue is full.
// Synchronous reset empties both queues, zeroes slot and free counts and
// sets the threshold to 32; no memory clearing pass is needed.
`default_nettype none

module generational_handle_allocator_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire gha_pkg::gha_req_type req_item,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output gha_pkg::gha_rsp_type      rsp_item,
   input  wire logic                 csr_we,
   input  wire logic [gha_pkg::THRESHOLD_BITS-1:0] csr_wdata
);
   import gha_pkg::*;

   logic        cmd_valid;
   gha_cmd_type cmd_head;
   logic        cmd_pop;
   logic        rsp_full;
   logic        rsp_push;
   gha_rsp_type push_item;

   gha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop)
   );

   gha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (push_item)
   );

   gha_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (push_item),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== src/gha_front.sv =====
// Front end: accepts requests, decodes the handle and holds them in a
// two-entry command queue for the back end. Depends on gha_pkg.
`default_nettype none

module gha_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire gha_pkg::gha_req_type req_item,
   output logic                      cmd_valid,
   output gha_pkg::gha_cmd_type      cmd_head,
   input  wire logic                 cmd_pop
);
   import gha_pkg::*;

   gha_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   gha_cmd_type decoded;
   logic        push_ok;
   logic        pop_ok;

   always_comb begin
      decoded.operation = req_item.operation;
      decoded.index     = req_item.handle[SLOT_BITS-1:0];
      decoded.gen       = req_item.handle[INDEX_BITS +: GEN_BITS];
      decoded.addr_ok   = (req_item.handle != '1) &&
                          (req_item.handle[INDEX_BITS-1:SLOT_BITS] == '0);
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_head  = entry_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// ===== src/gha_rsp_queue.sv =====
// Two-entry result queue between the back end and the result ports.
// Depends on gha_pkg.
`default_nettype none

module gha_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gha_pkg::gha_rsp_type push_item,
   output logic                      full,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output gha_pkg::gha_rsp_type      rsp_item
);
   import gha_pkg::*;

   gha_rsp_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push_ok;
   logic        pop_ok;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/gha_back.sv =====
// Back end: sequencer over the generation memory and the free-index queue,
// plus the threshold register. Depends on gha_pkg.
`default_nettype none

module gha_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [gha_pkg::THRESHOLD_BITS-1:0] csr_wdata,
   input  wire logic                  cmd_valid,
   input  wire gha_pkg::gha_cmd_type  cmd_head,
   output logic                       cmd_pop,
   input  wire logic                  rsp_full,
   output logic                       rsp_push,
   output gha_pkg::gha_rsp_type       rsp_item
);
   import gha_pkg::*;

   logic [GEN_BITS-1:0]  gen_mem [2**SLOT_BITS];
   logic [SLOT_BITS-1:0] q_mem   [2**SLOT_BITS];

   gha_state_type             state_ff, state_in;
   gha_cmd_type               cmd_ff, cmd_in;
   logic [SLOT_BITS:0]        slot_count_ff, slot_count_in;
   logic [SLOT_BITS-1:0]      head_ff, head_in;
   logic [SLOT_BITS-1:0]      tail_ff, tail_in;
   logic [SLOT_BITS:0]        count_ff, count_in;
   logic [THRESHOLD_BITS-1:0] thr_ff;

   logic [GEN_BITS-1:0]  gen_rd_ff;
   logic [SLOT_BITS-1:0] q_rd_ff;
   logic [SLOT_BITS-1:0] gen_raddr;
   logic                 gen_we;
   logic [SLOT_BITS-1:0] gen_waddr;
   logic [GEN_BITS-1:0]  gen_wdata;
   logic                 q_we;
   logic                 handle_ok;
   logic                 recycle;

   // generation of the dequeued index is read in the execute state for the lookup state
   assign gen_raddr = (state_ff == S_EXEC) ? q_rd_ff : cmd_head.index;

   assign handle_ok = cmd_ff.addr_ok &&
                      ({1'b0, cmd_ff.index} < slot_count_ff) &&
                      (gen_rd_ff == cmd_ff.gen);
   assign recycle   = (count_ff > WAIT_BITS'(thr_ff)) ||
                      ((slot_count_ff == SLOT_TOTAL) && (count_ff != '0));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_count_in = slot_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_item.status       = ST_INVALID;
      rsp_item.new_handle   = '0;
      rsp_item.free_waiting = count_ff;
      gen_we        = 1'b0;
      gen_waddr     = cmd_ff.index;
      gen_wdata     = cmd_ff.gen + 1'b1;
      q_we          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cmd_ff.operation)
               OP_ALLOC: begin
                  if (recycle) begin
                     head_in  = head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                     state_in = S_LOOKUP;
                  end else if (slot_count_ff != SLOT_TOTAL) begin
                     gen_we        = 1'b1;
                     gen_waddr     = slot_count_ff[SLOT_BITS-1:0];
                     gen_wdata     = '0;
                     slot_count_in = slot_count_ff + 1'b1;
                     rsp_push      = 1'b1;
                     rsp_item.status     = ST_OK;
                     rsp_item.new_handle =
                        make_handle(slot_count_ff[SLOT_BITS-1:0], '0);
                  end else begin
                     rsp_push        = 1'b1;
                     rsp_item.status = ST_FULL;
                  end
               end
               OP_RELEASE: begin
                  rsp_push = 1'b1;
                  if (handle_ok && (count_ff != SLOT_TOTAL)) begin
                     gen_we   = 1'b1;
                     q_we     = 1'b1;
                     tail_in  = tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     rsp_item.status       = ST_OK;
                     rsp_item.free_waiting = count_ff + 1'b1;
                  end
               end
               OP_CHECK: begin
                  rsp_push        = 1'b1;
                  rsp_item.status = handle_ok ? ST_OK : ST_INVALID;
               end
               default: begin
                  rsp_push = 1'b1;
               end
            endcase
         end
         S_LOOKUP: begin
            state_in            = S_IDLE;
            rsp_push            = 1'b1;
            rsp_item.status     = ST_OK;
            rsp_item.new_handle = make_handle(q_rd_ff, gen_rd_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         thr_ff        <= THRESHOLD_RESET;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // generation memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_waddr] <= gen_wdata;
      end
      gen_rd_ff <= gen_mem[gen_raddr];
   end

   // free-index queue; read data held after the issue cycle
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff] <= cmd_ff.index;
      end
      if (state_ff == S_IDLE) begin
         q_rd_ff <= q_mem[head_ff];
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOT_TOTAL)
      else $error("free count beyond slot total");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= SLOT_TOTAL)
      else $error("slot count beyond slot total");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      count_ff[SLOT_BITS-1:0] == SLOT_BITS'(tail_ff - head_ff))
      else $error("queue pointers disagree with free count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_lookup_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOOKUP |-> $past(state_ff) == S_EXEC)
      else $error("lookup not preceded by execute");

endmodule

`default_nettype wire
